[rtl/tc_iir_pkg.sv]
`timescale 1ns / 1ps

package tc_iir_pkg;

    // Fixed field widths
    localparam int CHANNEL_W        = 4;
    localparam int COUNT_W          = 16;
    localparam int FACTOR_W         = 8;
    localparam int CHAN_EN_W        = 10;
    localparam int CFG_DATA_W       = 10;
    localparam int CFG_IDX_W        = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_FACTOR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 1'b1;

    // Reset values
    localparam logic [FACTOR_W-1:0]  FILTER_FACTOR_RST  = 8'd4;
    localparam logic [CHAN_EN_W-1:0] CHANNEL_ENABLE_RST = '0;

    // Parameter defaults
    localparam int NUM_CHANNELS_DEF  = 10;
    localparam int FRACTION_BITS_DEF = 4;

    // Channel vector as seen through a 4-bit channel number
    localparam int CHAN_SPACE = 2 ** CHANNEL_W;

    typedef logic [CHANNEL_W-1:0] channel_t;

endpackage

[rtl/touch_channel_iir_smoother.sv]
`timescale 1ns / 1ps

// Per-channel touch count smoother. Each beat on the input carries a channel
// number and a 16-bit raw count; for an enabled channel the block runs one
// step of a first-order IIR filter, acc = (scaled + (k-1)*acc) / k rounded
// down, where scaled is the raw count shifted up by FRACTION_BITS and k is
// filter_factor (k = 0 passes the sample through). An accumulator of zero
// means "not yet seeded" and is first loaded with the scaled sample. One
// output beat per enabled sample carries the channel and the accumulator
// rounded back to a whole count. Samples for disabled or out-of-range
// channels are dropped without an output beat and leave the state alone.
// Items are processed one at a time: an enabled sample goes from acceptance
// through the multiply step and the divide steps to the result register; the
// restoring divider produces one quotient bit per cycle, and with k = 0 the
// divide is skipped. The next sample can be taken in the cycle after the
// result is registered. A dropped sample does not hold the input: another
// beat can follow at the next edge. The output register decouples the sides,
// so a new sample is taken while a result still waits; that sample holds in
// its last step until the waiting result has gone.
// The accumulators are cleared by reset; configuration writes take effect
// at once and are expected only while the block is idle.
module touch_channel_iir_smoother
    import tc_iir_pkg::*;
#(
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CHANNEL_W-1:0]  channel,
    input  logic [COUNT_W-1:0]    raw_count,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHANNEL_W-1:0]  channel_out,
    output logic [COUNT_W-1:0]    smoothed_value
);

    // Accumulator and numerator widths
    localparam int ACC_W   = COUNT_W + FRACTION_BITS;
    localparam int NUM_W   = ACC_W + FACTOR_W;
    localparam int CNT_W   = $clog2(ACC_W + 1);
    localparam int IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [ACC_W:0] ROUND_TERM = (ACC_W + 1)'((1 << FRACTION_BITS) >> 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [FACTOR_W-1:0]   factor_reg;
    logic [CHAN_EN_W-1:0]  enable_reg;
    logic [ACC_W-1:0]      acc_store_reg [NUM_CHANNELS];

    channel_t              ch_reg;
    logic [ACC_W-1:0]      scaled_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [FACTOR_W-1:0]   rem_reg, rem_next;
    logic [ACC_W-1:0]      quo_reg, quo_next;      // dividend bits in, quotient bits out
    logic [CNT_W-1:0]      cnt_reg;

    logic                  out_valid_reg;
    channel_t              out_ch_reg;
    logic [COUNT_W-1:0]    out_val_reg;

    // Input side decode
    logic [CHAN_SPACE-1:0] en_ext;
    logic                  ch_in_range;
    logic                  ch_enabled;
    logic                  in_fire;
    logic [IDX_W-1:0]      in_idx;
    logic [ACC_W-1:0]      acc_rd;
    logic [ACC_W-1:0]      scaled_in;

    assign en_ext      = CHAN_SPACE'(enable_reg);
    assign ch_in_range = ({1'b0, channel} < (CHANNEL_W + 1)'(NUM_CHANNELS));
    assign ch_enabled  = ch_in_range && en_ext[channel];
    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign in_idx      = IDX_W'(channel);
    assign acc_rd      = ch_in_range ? acc_store_reg[in_idx] : '0;
    assign scaled_in   = ACC_W'(raw_count) << FRACTION_BITS;

    // Numerator: scaled + (k-1)*acc, registered straight into the divider
    logic [NUM_W-1:0]      numerator;
    assign numerator = NUM_W'(factor_reg - 1'b1) * NUM_W'(acc_reg) + NUM_W'(scaled_reg);

    // One restoring divide step per cycle
    logic [FACTOR_W:0]     trial;
    logic [FACTOR_W:0]     trial_diff;
    logic                  q_bit;

    assign trial      = {rem_reg, quo_reg[ACC_W-1]};
    assign trial_diff = trial - {1'b0, factor_reg};
    assign q_bit      = (trial >= {1'b0, factor_reg});

    always_comb
    begin
        rem_next = q_bit ? trial_diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
        quo_next = {quo_reg[ACC_W-2:0], q_bit};
    end

    // Result rounding
    logic [ACC_W:0]        rounded;
    logic                  out_free;

    assign rounded  = {1'b0, quo_reg} + ROUND_TERM;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && ch_enabled)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = (factor_reg == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            factor_reg    <= FILTER_FACTOR_RST;
            enable_reg    <= CHANNEL_ENABLE_RST;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FILTER_FACTOR:  factor_reg <= cfg_data[FACTOR_W-1:0];
                    REG_CHANNEL_ENABLE: enable_reg <= cfg_data[CHAN_EN_W-1:0];
                    default:            ;
                endcase
            end
            if (state_reg == ST_MUL)
            begin
                cnt_reg <= CNT_W'(ACC_W);
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Accumulator store, cleared by reset (zero = unseeded)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                acc_store_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            acc_store_reg[IDX_W'(ch_reg)] <= quo_reg;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ch_reg     <= channel;
                    scaled_reg <= scaled_in;
                    acc_reg    <= (acc_rd == '0) ? scaled_in : acc_rd;
                end
            end
            ST_MUL:
            begin
                if (factor_reg == '0)
                begin
                    quo_reg <= scaled_reg;
                end
                else
                begin
                    rem_reg <= numerator[NUM_W-1:ACC_W];
                    quo_reg <= numerator[ACC_W-1:0];
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_ch_reg  <= ch_reg;
                    out_val_reg <= rounded[FRACTION_BITS +: COUNT_W];
                end
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign channel_out    = out_ch_reg;
    assign smoothed_value = out_val_reg;

`ifndef NO_ASSERTIONS
    // Divider remainder must stay below the divisor
    a_rem_below_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < factor_reg))
        else $error("divider remainder not below filter factor");

    // A dropped sample must not start the sequencer
    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !ch_enabled) |=> (state_reg == ST_IDLE))
        else $error("dropped sample started processing");

    // Result register is loaded only on leaving the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("output beat without completed item");

    // Finished item lands in the output with its channel
    a_out_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=>
            (out_valid_reg && channel_out == $past(ch_reg)))
        else $error("output beat carries wrong channel");
`endif

endmodule

[bench/touch_smoother_checker.sv]
`timescale 1ns / 1ps

// Watches the config port and both channels and keeps its own copy of the
// per-channel filter state. It predicts each smoothed beat and checks the
// output beats against those predictions, oldest first.
module touch_smoother_checker
    import tc_iir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [CHANNEL_W-1:0]  channel,
    input  logic [COUNT_W-1:0]    raw_count,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [CHANNEL_W-1:0]  channel_out,
    input  logic [COUNT_W-1:0]    smoothed_value,

    output int                    mismatch_count,
    output int                    beats_checked,
    output int                    beats_owed
);

    localparam int ACC_W = COUNT_W + FRACTION_BITS_DEF;
    localparam logic [ACC_W:0] HALF_LSB = (ACC_W + 1)'((1 << FRACTION_BITS_DEF) >> 1);

    typedef struct packed {
        channel_t             chan;
        logic [COUNT_W-1:0]   value;
    } smoothed_beat_t;

    logic [FACTOR_W-1:0]  divisor_k;
    logic [CHAN_EN_W-1:0] enabled;
    logic [ACC_W-1:0]     accum [NUM_CHANNELS_DEF];
    smoothed_beat_t       smoothed_due [$];
    int                   errors = 0;
    int                   checked = 0;

    assign mismatch_count = errors;
    assign beats_checked  = checked;

    // One IIR step; k = 0 passes the scaled sample straight through
    function automatic logic [ACC_W-1:0] iir_next(input logic [ACC_W-1:0]    scaled,
                                                  input logic [ACC_W-1:0]    acc,
                                                  input logic [FACTOR_W-1:0] k);
        logic [63:0] blend;
        if (k == '0)
            return scaled;
        blend = (64'(scaled) + (64'(k) - 64'd1) * 64'(acc)) / 64'(k);
        return blend[ACC_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic predict_sample(input channel_t ch, input logic [COUNT_W-1:0] raw);
        logic [ACC_W-1:0] scaled;
        logic [ACC_W-1:0] acc;
        logic [ACC_W:0]   rounded;
        smoothed_beat_t   beat;
        // out-of-range or disabled: dropped, state untouched
        if (ch >= NUM_CHANNELS_DEF || !enabled[ch])
            return;
        scaled = ACC_W'(raw) << FRACTION_BITS_DEF;
        acc    = accum[ch];
        if (acc == '0)
            acc = scaled;   // unseeded channel takes the sample as its start
        accum[ch]  = iir_next(scaled, acc, divisor_k);
        rounded    = ({1'b0, accum[ch]} + HALF_LSB) >> FRACTION_BITS_DEF;
        beat.chan  = ch;
        beat.value = rounded[COUNT_W-1:0];
        smoothed_due.push_back(beat);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        smoothed_beat_t want;
        if (!rst_n)
        begin
            divisor_k = FILTER_FACTOR_RST;
            enabled   = CHANNEL_ENABLE_RST;
            foreach (accum[i])
                accum[i] = '0;
            smoothed_due.delete();
            beats_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (smoothed_due.size() == 0)
                    report_mismatch($sformatf("unexpected beat ch=%0d value=%0d",
                                              channel_out, smoothed_value));
                else
                begin
                    want = smoothed_due.pop_front();
                    checked++;
                    if (channel_out !== want.chan)
                        report_mismatch($sformatf("channel_out %0d, want %0d",
                                                  channel_out, want.chan));
                    if (smoothed_value !== want.value)
                        report_mismatch($sformatf("ch %0d smoothed_value %0d, want %0d",
                                                  want.chan, smoothed_value, want.value));
                end
            end
            if (in_valid && in_ready)
                predict_sample(channel, raw_count);
            if (cfg_write)
            begin
                if (cfg_index == REG_FILTER_FACTOR)
                    divisor_k = cfg_data[FACTOR_W-1:0];
                else if (cfg_index == REG_CHANNEL_ENABLE)
                    enabled = cfg_data[CHAN_EN_W-1:0];
            end
            beats_owed <= smoothed_due.size();
        end
    end

endmodule

[bench/tb_touch_channel_iir_smoother.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the touch channel smoother. Checking lives in
// touch_smoother_checker; this module only drives beats, config writes and
// back-pressure, then reads the checker's mismatch count at the end.
module tb_touch_channel_iir_smoother;
    import tc_iir_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 40;   // longer than a full divide, plus margin
    localparam int SEGMENTS      = 6;    // register settings per phase
    localparam int SEG_BEATS     = 50;   // target filtered samples per segment

    // Handshake phases: sender idle and receiver stall, percent
    int idle_plan  [4] = '{0, 62, 0, 26};
    int stall_plan [4] = '{0, 0, 62, 26};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [CHANNEL_W-1:0]  channel   = '0;
    logic [COUNT_W-1:0]    raw_count = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CHANNEL_W-1:0]  channel_out;
    logic [COUNT_W-1:0]    smoothed_value;

    int mismatch_count;
    int beats_checked;
    int beats_owed;

    int idle_pct         = 0;
    int stall_pct        = 0;
    int cycle_count      = 0;
    int samples_sent     = 0;
    int samples_filtered = 0;
    int reg_writes       = 0;
    logic [CHAN_EN_W-1:0] mask_now = CHANNEL_ENABLE_RST;

    touch_channel_iir_smoother u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .channel        (channel),
        .raw_count      (raw_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel_out    (channel_out),
        .smoothed_value (smoothed_value)
    );

    touch_smoother_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .channel        (channel),
        .raw_count      (raw_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel_out    (channel_out),
        .smoothed_value (smoothed_value),
        .mismatch_count (mismatch_count),
        .beats_checked  (beats_checked),
        .beats_owed     (beats_owed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost beat ends up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d beats still owed",
                     cycle_count, beats_owed);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle; one assignment per edge
    always @(posedge clk)
    begin
        out_ready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
    end

    // Offer one input beat and hold it until the block takes it. Valid is
    // left high on return so back-to-back beats never drop it; it only
    // falls when a sender gap is drawn or the stream stops.
    task automatic send_sample(input channel_t ch, input logic [COUNT_W-1:0] raw);
        int gap;
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            gap = $urandom_range(30, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        channel   <= ch;
        raw_count <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
        if (ch < NUM_CHANNELS_DEF && mask_now[ch])
            samples_filtered++;
    endtask

    // Stop offering, let every owed beat drain, then give a dropped sample
    // or a late divide time to finish before touching the registers.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_CHANNEL_ENABLE)
            mask_now = data[CHAN_EN_W-1:0];
        reg_writes++;
    endtask

    initial
    begin
        int                   ph;
        int                   sg;
        int                   sent;
        int                   start_filtered;
        int                   cap;
        logic [FACTOR_W-1:0]  k_pick;
        logic [CHAN_EN_W-1:0] m_pick;
        channel_t             ch;
        logic [COUNT_W-1:0]   raw;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // everything disabled out of reset: sample is swallowed
        send_sample(4'd0, 16'h1234);
        wait_idle();
        write_reg(REG_CHANNEL_ENABLE, 10'h3FF);
        // channel numbers past the last channel are dropped
        send_sample(4'd10, 16'h5A5A);
        send_sample(4'd15, 16'hFFFF);
        // zero on an unseeded channel stays unseeded, next sample seeds
        send_sample(4'd0, 16'h0000);
        send_sample(4'd0, 16'hFFFF);
        // decay towards zero at the reset divisor of 4
        send_sample(4'd0, 16'h0000);
        send_sample(4'd0, 16'h0000);
        send_sample(4'd9, 16'hFFFF);
        send_sample(4'd9, 16'h0001);
        for (int c = 1; c <= 8; c++)
            send_sample(channel_t'(c), COUNT_W'(c * 16'h1111));
        // disabling channel 9 must keep its accumulator for later
        wait_idle();
        write_reg(REG_CHANNEL_ENABLE, 10'h1FF);
        send_sample(4'd9, 16'h0000);
        wait_idle();
        write_reg(REG_CHANNEL_ENABLE, 10'h3FF);
        send_sample(4'd9, 16'h8000);
        // k = 0: straight pass-through
        wait_idle();
        write_reg(REG_FILTER_FACTOR, 10'h000);
        send_sample(4'd3, 16'hABCD);
        // largest divisor: very slow response
        wait_idle();
        write_reg(REG_FILTER_FACTOR, 10'h0FF);
        send_sample(4'd3, 16'h0000);
        send_sample(4'd3, 16'hFFFF);
        // top data bits must be ignored by the factor register; k = 1
        wait_idle();
        write_reg(REG_FILTER_FACTOR, 10'h301);
        send_sample(4'd5, 16'h0F0F);
        wait_idle();
        write_reg(REG_FILTER_FACTOR, 10'h002);
        send_sample(4'd0, 16'h7FFF);

        // ---- random, one pass per handshake phase ----
        for (ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_plan[ph];
            stall_pct = stall_plan[ph];
            for (sg = 0; sg < SEGMENTS; sg++)
            begin
                wait_idle();
                case (sg)
                    0:       begin k_pick = 8'd255; m_pick = 10'h3FF; end
                    1:       begin k_pick = 8'd0;
                                   m_pick = CHAN_EN_W'(1) << $urandom_range(9, 0); end
                    2:       begin k_pick = 8'd1; m_pick = '0; end
                    3:       begin k_pick = FILTER_FACTOR_RST;
                                   m_pick = CHAN_EN_W'($urandom_range(1023, 0)); end
                    default:
                    begin
                        k_pick = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(3, 1))
                                                             : 8'($urandom_range(255, 0));
                        m_pick = ($urandom_range(2, 0) == 0) ? 10'h3FF
                                                             : CHAN_EN_W'($urandom_range(1023, 0));
                    end
                endcase
                write_reg(REG_FILTER_FACTOR, {2'($urandom_range(3, 0)), k_pick});
                write_reg(REG_CHANNEL_ENABLE, m_pick);

                // an all-disabled mask only needs a short burst of dropped beats
                cap            = (mask_now == '0) ? 12 : 4 * SEG_BEATS;
                sent           = 0;
                start_filtered = samples_filtered;
                while (samples_filtered - start_filtered < SEG_BEATS && sent < cap)
                begin
                    // mostly enabled channels, the rest anywhere in the 4-bit space
                    if (mask_now != '0 && $urandom_range(3, 0) != 0)
                        do
                            ch = channel_t'($urandom_range(9, 0));
                        while (!mask_now[ch]);
                    else
                        ch = channel_t'($urandom_range(15, 0));
                    // zeros let accumulators decay and reseed; extremes test the top end
                    case ($urandom_range(9, 0))
                        0:       raw = '0;
                        1:       raw = '1;
                        2:       raw = COUNT_W'($urandom_range(15, 0));
                        3:       raw = COUNT_W'($urandom_range(65535, 65520));
                        default: raw = COUNT_W'($urandom_range(65535, 0));
                    endcase
                    send_sample(ch, raw);
                    sent++;
                end
            end
        end

        idle_pct = 0;
        wait_idle();

        $display("Run covered %0d samples (%0d on enabled channels) and %0d register writes",
                 samples_sent, samples_filtered, reg_writes);
        $display("across four idle/stall phases; %0d smoothed beats compared",
                 beats_checked);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
